[hdl/zsd_pkg.sv]
package zsd_pkg;

    // Sample and accumulator widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int DATA_W       = 16;
    localparam int SUM_W        = SAMPLE_WIDTH + 2;

    // Line geometry
    localparam int LINE_LENGTH  = 2048;
    localparam int POS_W        = $clog2(LINE_LENGTH);
    localparam int END_W        = POS_W + 1;
    localparam int NUM_ZONES    = 9;
    localparam int ZONE_W       = $clog2(NUM_ZONES);
    localparam int PHASE_W      = 2;

    localparam int EDGE_IN      = 121;
    localparam int FAR_IN       = 93;
    localparam int MID_IN       = 166;
    localparam int NEAR_IN      = 330;
    localparam int NADIR_IN     = 628;

    localparam int E0 = EDGE_IN;
    localparam int E1 = E0 + FAR_IN;
    localparam int E2 = E1 + MID_IN;
    localparam int E3 = E2 + NEAR_IN;
    localparam int E4 = E3 + NADIR_IN;
    localparam int E5 = E4 + NEAR_IN;
    localparam int E6 = E5 + MID_IN;
    localparam int E7 = E6 + FAR_IN;
    localparam int E8 = E7 + EDGE_IN;

    localparam logic [ZONE_W-1:0] LAST_ZONE = ZONE_W'(NUM_ZONES - 1);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(LINE_LENGTH - 1);

    // Command queue depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef logic [ZONE_W-1:0]       zone_t;
    typedef logic [PHASE_W-1:0]      phase_t;
    typedef logic [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [SUM_W-1:0]        sum_t;

    typedef enum logic [2:0] {
        KIND_PASS,
        KIND_PAIR,
        KIND_TRIPLE,
        KIND_QUAD,
        KIND_ONE_HALF
    } kind_t;

    // What the back end does with one sample
    typedef enum logic [2:0] {
        OP_PASS,    // emit sample as is
        OP_HOLD,    // hold sample for the next 1.5 output
        OP_HALF,    // emit (held + sample) / 2, hold sample
        OP_LOAD,    // start a new group sum
        OP_ACC      // add to group sum
    } op_t;

    typedef enum logic [1:0] {
        DIV_1,
        DIV_2,
        DIV_3,
        DIV_4
    } div_t;

    typedef struct packed {
        sample_t sample;
        op_t     op;
        logic    emit;
        div_t    div;
        logic    line_end;
    } cmd_t;

    function automatic logic [END_W-1:0] zone_end(input zone_t z);
        logic [END_W-1:0] e;
        unique case (z)
            4'd0:    e = END_W'(E0);
            4'd1:    e = END_W'(E1);
            4'd2:    e = END_W'(E2);
            4'd3:    e = END_W'(E3);
            4'd4:    e = END_W'(E4);
            4'd5:    e = END_W'(E5);
            4'd6:    e = END_W'(E6);
            4'd7:    e = END_W'(E7);
            default: e = END_W'(E8);
        endcase
        return e;
    endfunction

    function automatic kind_t zone_kind(input zone_t z);
        kind_t k;
        unique case (z)
            4'd1, 4'd7: k = KIND_ONE_HALF;
            4'd2, 4'd6: k = KIND_PAIR;
            4'd3, 4'd5: k = KIND_TRIPLE;
            4'd4:       k = KIND_QUAD;
            default:    k = KIND_PASS;
        endcase
        return k;
    endfunction

    // Index of the last sample in a group of the given kind
    function automatic phase_t last_phase(input kind_t k);
        phase_t p;
        unique case (k)
            KIND_PAIR:                 p = 2'd1;
            KIND_TRIPLE, KIND_ONE_HALF: p = 2'd2;
            KIND_QUAD:                 p = 2'd3;
            default:                   p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

[hdl/zsd_front.sv]
module zsd_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [zsd_pkg::DATA_W-1:0]   s_tdata,   // [15:0] in_sample
    input  logic                         q_full,
    output logic                         q_push,
    output zsd_pkg::cmd_t                q_cmd
);
    import zsd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    zone_t            zone_reg, zone_next;
    phase_t           phase_reg, phase_next;

    logic [END_W-1:0] pos_inc;
    logic             zone_done;
    logic             group_last;
    kind_t            kind;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign kind       = zone_kind(zone_reg);
    assign pos_inc    = {1'b0, pos_reg} + END_W'(1);
    assign zone_done  = (pos_inc == zone_end(zone_reg));
    assign group_last = (phase_reg == last_phase(kind));

    always_comb begin
        q_cmd.sample   = s_tdata[SAMPLE_WIDTH-1:0];
        q_cmd.line_end = (pos_reg == LAST_POS);
        q_cmd.op       = OP_PASS;
        q_cmd.emit     = 1'b1;
        q_cmd.div      = DIV_1;
        unique case (kind)
            KIND_PASS: begin
                q_cmd.op   = OP_PASS;
                q_cmd.emit = 1'b1;
            end
            KIND_ONE_HALF: begin
                q_cmd.op   = (phase_reg == '0) ? OP_HOLD : OP_HALF;
                q_cmd.emit = (phase_reg != '0);
                q_cmd.div  = DIV_2;
            end
            KIND_PAIR, KIND_TRIPLE, KIND_QUAD: begin
                q_cmd.op   = (phase_reg == '0) ? OP_LOAD : OP_ACC;
                q_cmd.emit = group_last;
                unique case (kind)
                    KIND_PAIR:   q_cmd.div = DIV_2;
                    KIND_TRIPLE: q_cmd.div = DIV_3;
                    default:     q_cmd.div = DIV_4;
                endcase
            end
            default: begin
                q_cmd.op   = OP_PASS;
                q_cmd.emit = 1'b1;
            end
        endcase
    end

    always_comb begin
        pos_next   = pos_reg;
        zone_next  = zone_reg;
        phase_next = phase_reg;
        if (q_push) begin
            pos_next = pos_inc[POS_W-1:0];
            if (zone_done) begin
                zone_next  = (zone_reg == LAST_ZONE) ? '0 : zone_reg + ZONE_W'(1);
                phase_next = '0;
            end else if (group_last) begin
                phase_next = '0;
            end else begin
                phase_next = phase_reg + PHASE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            zone_reg  <= '0;
            phase_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            zone_reg  <= zone_next;
            phase_reg <= phase_next;
        end
    end

    a_last_pos_last_zone: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == LAST_POS) |-> (zone_reg == LAST_ZONE && group_last))
        else $error("line end outside the last zone");

    a_line_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == '0) |-> (zone_reg == '0 && phase_reg == '0))
        else $error("line start not aligned to first zone");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= last_phase(kind))
        else $error("group phase out of range");

endmodule

[hdl/zsd_cmd_fifo.sv]
module zsd_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  zsd_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output zsd_pkg::cmd_t  pop_cmd
);
    import zsd_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign avail   = (count_reg != '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> avail)
        else $error("pop from empty queue");

endmodule

[hdl/zsd_back.sv]
module zsd_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_avail,
    input  zsd_pkg::cmd_t                q_cmd,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [zsd_pkg::DATA_W-1:0]   m_tdata,   // [15:0] out_sample
    output logic                         m_tlast
);
    import zsd_pkg::*;

    localparam int              PROD_W = 2 * SUM_W;
    localparam logic [SUM_W-1:0] RECIP3 = SUM_W'((2 ** (SUM_W + 1) + 2) / 3);

    // Running state
    sum_t    sum_reg, sum_next;
    sample_t held_reg, held_next;

    // Stage 1: numerator waiting for its divide
    logic    s1_valid_reg, s1_valid_next;
    sum_t    s1_num_reg, s1_num_next;
    div_t    s1_div_reg, s1_div_next;
    logic    s1_last_reg, s1_last_next;

    // Stage 2: output register
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic              out_adv;
    sum_t              x_ext;
    sum_t              acc;
    logic [PROD_W-1:0] prod;
    sample_t           quot;

    assign out_adv = !out_valid_reg || m_tready;
    assign q_pop   = q_avail && (!s1_valid_reg || out_adv);
    assign x_ext   = SUM_W'(q_cmd.sample);
    assign acc     = sum_reg + x_ext;

    always_comb begin
        sum_next      = sum_reg;
        held_next     = held_reg;
        s1_num_next   = s1_num_reg;
        s1_div_next   = s1_div_reg;
        s1_last_next  = s1_last_reg;
        s1_valid_next = s1_valid_reg && !out_adv;
        if (q_pop) begin
            s1_valid_next = q_cmd.emit;
            s1_div_next   = q_cmd.div;
            s1_last_next  = q_cmd.line_end;
            unique case (q_cmd.op)
                OP_PASS: begin
                    s1_num_next = x_ext;
                end
                OP_HOLD: begin
                    held_next = q_cmd.sample;
                end
                OP_HALF: begin
                    s1_num_next = SUM_W'(held_reg) + x_ext;
                    held_next   = q_cmd.sample;
                end
                OP_LOAD: begin
                    sum_next = x_ext;
                end
                OP_ACC: begin
                    sum_next    = acc;
                    s1_num_next = acc;
                end
                default: begin
                    s1_num_next = x_ext;
                end
            endcase
        end
    end

    // Divide by three as a multiply by the rounded-up reciprocal
    assign prod = {{SUM_W{1'b0}}, s1_num_reg} * {{SUM_W{1'b0}}, RECIP3};
    assign quot = prod[SUM_W + 1 +: SAMPLE_WIDTH];

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (out_adv) begin
            out_valid_next = s1_valid_reg;
            out_last_next  = s1_last_reg;
            unique case (s1_div_reg)
                DIV_1:   out_data_next = DATA_W'(s1_num_reg[SAMPLE_WIDTH-1:0]);
                DIV_2:   out_data_next = DATA_W'(s1_num_reg[SAMPLE_WIDTH:1]);
                DIV_3:   out_data_next = DATA_W'(quot);
                default: out_data_next = DATA_W'(s1_num_reg[SAMPLE_WIDTH+1:2]);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        sum_next_hold: begin
            sum_reg      <= sum_next;
            held_reg     <= held_next;
            s1_num_reg   <= s1_num_next;
            s1_div_reg   <= s1_div_next;
            s1_last_reg  <= s1_last_next;
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_s1_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_adv) |=> (s1_valid_reg && $stable(s1_num_reg)))
        else $error("stage 1 lost data during output stall");

endmodule

[hdl/zoned_scanline_downsampler.sv]
// An accepted input transaction is written into the command queue, read into
// stage 1, then divided into the output register. Throughput: one input
// transaction per cycle while the queue is not full; 909 output transactions per
// 2048-sample line. The 4-entry command queue and the output register decouple
// the two sides so either can stall alone. Reset: aresetn (synchronous, active
// low) clears line position, zone, queue and valid flags; no clearing pass.
module zoned_scanline_downsampler (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [zsd_pkg::DATA_W-1:0]   s_tdata,   // [15:0] in_sample
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [zsd_pkg::DATA_W-1:0]   m_tdata,   // [15:0] out_sample
    output logic                         m_tlast    // line_end
);
    import zsd_pkg::*;

    // Front end to queue
    logic q_full;
    logic q_push;
    cmd_t q_in_cmd;

    // Queue to back end
    logic q_avail;
    logic q_pop;
    cmd_t q_out_cmd;

    // Track line position and zone; turn each transaction into a command
    zsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    // Hold commands so the front keeps accepting while the back stalls
    zsd_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .pop_cmd  (q_out_cmd)
    );

    // Accumulate groups, divide, and drive the output register
    zsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_avail  (q_avail),
        .q_cmd    (q_out_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[verif/zoned_scanline_downsampler_test.sv]
`timescale 1ns / 1ps

module zoned_scanline_downsampler_test;

    import zsd_pkg::*;

    // One expected output transaction: resampled pixel plus end-of-line flag
    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              line_end;
    } pixel_t;

    // Tracks the line position on its own, predicts every output pixel and
    // checks the output stream against the predictions in order.
    class resample_checker;
        int           zone_limit[NUM_ZONES];
        kind_t        zone_type[NUM_ZONES];
        logic [10:0]  line_pos;
        logic [17:0]  group_sum;
        logic [15:0]  held_pixel;
        pixel_t       expected_pixels[$];
        int           failures;

        function new();
            zone_limit = '{E0, E1, E2, E3, E4, E5, E6, E7, E8};
            zone_type  = '{KIND_PASS, KIND_ONE_HALF, KIND_PAIR, KIND_TRIPLE, KIND_QUAD,
                           KIND_TRIPLE, KIND_PAIR, KIND_ONE_HALF, KIND_PASS};
            line_pos   = '0;
            group_sum  = '0;
            held_pixel = '0;
            failures   = 0;
        endfunction

        // Advance the line model by one accepted input sample
        function void note_sample(logic [DATA_W-1:0] x);
            int     cur;
            int     zone_start;
            int     group_len;
            int     phase;
            bit     found;
            bit     emit;
            kind_t  kind;
            logic [15:0] value;
            pixel_t px;
            cur        = int'(line_pos);
            zone_start = 0;
            kind       = KIND_PASS;
            found      = 1'b0;
            emit       = 1'b0;
            value      = '0;
            for (int z = 0; z < NUM_ZONES; z++) begin
                if (!found) begin
                    if (cur < zone_limit[z]) begin
                        kind  = zone_type[z];
                        found = 1'b1;
                    end else begin
                        zone_start = zone_limit[z];
                    end
                end
            end
            case (kind)
                KIND_PASS: begin
                    value = x;
                    emit  = 1'b1;
                end
                KIND_ONE_HALF: begin
                    // groups of three: a, b, c -> (a+b)/2 after b, (b+c)/2 after c
                    phase = (cur - zone_start) % 3;
                    if (phase != 0) begin
                        value = 16'((17'(held_pixel) + 17'(x)) >> 1);
                        emit  = 1'b1;
                    end
                    held_pixel = x;
                end
                default: begin
                    group_len = (kind == KIND_PAIR) ? 2 : (kind == KIND_TRIPLE) ? 3 : 4;
                    phase     = (cur - zone_start) % group_len;
                    if (phase == 0)
                        group_sum = 18'(x);
                    else
                        group_sum = group_sum + 18'(x);
                    if (phase == group_len - 1) begin
                        value = 16'(int'(group_sum) / group_len);
                        emit  = 1'b1;
                    end
                end
            endcase
            line_pos = line_pos + 11'd1;
            if (emit) begin
                px.sample   = value;
                px.line_end = (cur == LINE_LENGTH - 1);
                expected_pixels.push_back(px);
            end
        endfunction

        // Compare one output transaction against the oldest prediction
        function void check_pixel(logic [DATA_W-1:0] sample, logic line_end);
            pixel_t exp_px;
            if (expected_pixels.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR %0t: unexpected output sample=%h last=%b",
                             $realtime, sample, line_end);
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (sample !== exp_px.sample || line_end !== exp_px.line_end) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR %0t: sample exp %h got %h, last exp %b got %b",
                             $realtime, exp_px.sample, sample, exp_px.line_end, line_end);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1588;
    localparam int NUM_PHASES   = 4;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;     // [15:0] in_sample
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;     // [15:0] out_sample
    logic              m_tlast;     // line_end

    // Percent of cycles each side holds off; changed between phases
    int send_idle_pct;
    int recv_stall_pct;

    resample_checker checker_h;

    zoned_scanline_downsampler DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Drop ready at random to back-pressure the output side
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Sample both channels at the edge; values seen here are the pre-edge ones
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            checker_h.note_sample(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            checker_h.check_pixel(m_tdata, m_tlast);
    end

    // Offer one sample: insert random idle cycles first, then hold valid until
    // the transaction is taken. Valid stays high on return so back-to-back
    // samples need no extra cycle.
    task automatic send_sample(logic [DATA_W-1:0] x);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // Pick a random sample, biased toward the extremes so group sums reach
    // their maximum and truncation of odd sums shows up.
    function automatic logic [DATA_W-1:0] pick_sample();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            2:       v = 16'hFFF0 | 16'($urandom_range(0, 15));
            3:       v = 16'($urandom_range(0, 15));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [DATA_W-1:0] directed[$];
        logic [DATA_W-1:0] run_val;
        int                run_left;
        int                per_phase;

        checker_h      = new();
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_left       = 0;
        run_val        = '0;
        per_phase      = RANDOM_ITEMS / NUM_PHASES;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes and single-bit patterns, all in the leading
        // pass-through zone, so every bit is seen both ways on the output too
        directed = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA,
                     16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE, 16'h00FF, 16'hFF00};
        foreach (directed[i])
            send_sample(directed[i]);

        // Random part: runs from the leading edge zone through nadir into the
        // trailing triple zone, so every kind of zone and group boundary is hit.
        // Phases: no idling, sender idle, receiver stalling, both lightly.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int i = 0; i < per_phase; i++) begin
                // Occasionally repeat one extreme value to fill whole groups
                if (run_left == 0 && $urandom_range(0, 19) == 0) begin
                    run_left = $urandom_range(4, 12);
                    run_val  = $urandom_range(0, 1) ? '1 : '0;
                end
                if (run_left > 0) begin
                    run_left--;
                    send_sample(run_val);
                end else begin
                    send_sample(pick_sample());
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain the output side, then allow for the pipeline latency
        recv_stall_pct = 0;
        while (checker_h.pending() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (checker_h.failures == 0 && checker_h.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
